// ----- hdl/spmb_pkg.sv -----
// package for the stereo peak meter ballistics block
// request and register codes, field widths, reset values and decay constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spmb_pkg;

    // default widths of the level state and the hold counter
    localparam int LEVEL_BITS_DEF = 16;
    localparam int HOLD_BITS_DEF  = 10;

    // fixed widths of the port fields
    localparam int VALUE_W    = 16;
    localparam int REQ_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_CFG_W = 10;
    localparam int STEP_W     = 16;
    localparam int FACTOR_W   = 16;

    // configuration reset values
    localparam logic [HOLD_CFG_W-1:0] HOLD_TICKS_RST  = 10'd30;
    localparam logic [STEP_W-1:0]     DECAY_STEP_RST  = 16'd164;
    localparam logic [FACTOR_W-1:0]   SMOOTH_F_RST    = 16'd19661;

    // per-tick decay factors in q0.16
    localparam int DECAY_LEVEL_Q16 = 58982;
    localparam int DECAY_RMS_Q16   = 62259;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET_LEVEL = 3'd0,
        REQ_SET_RMS   = 3'd1,
        REQ_TICK      = 3'd2,
        REQ_CLR_CLIP  = 3'd3,
        REQ_CLR_PEAK  = 3'd4
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS = 2'd0,
        CFG_DECAY_STEP = 2'd1,
        CFG_SMOOTH_F   = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- hdl/stereo_peak_meter_ballistics_top.sv -----
// top level of the stereo peak meter ballistics block
// per-channel level, rms, peak hold and clip state with a registered result
// depends on spmb_pkg
`timescale 1ns / 1ps
`default_nettype none

// stereo level meter ballistics, two channels of unsigned q2.14 levels
//
// input channel (i_in_valid / o_in_ready) carries a request code and one value
// per channel: set levels, set rms, display tick, clear clip, clear peaks.
// every transfer in yields exactly one transfer out (o_out_valid / i_out_ready)
// that shows smoothed level, rms, held peak and clip latch after the request.
//
// pipeline: the request is captured in an input register; when the result
// slot is free, the channel state is updated and the result register is
// loaded from the same short multiply/compare logic.
// throughput: one request per cycle while results are taken, the state update
// for a request finishes in the cycle it leaves the input register (one
// smoothing multiply plus two constant multiplies per channel).
//
// when the receiver stalls the result register holds, the input register
// holds behind it and o_in_ready drops; nothing is lost or repeated.
// synchronous active-low reset clears both valid flags and all channel state
// and loads the register defaults (hold 30, step 164, smoothing 19661).
// configuration writes take effect at the edge where i_cfg_wr_en is high and
// are expected only while the block is idle.
module stereo_peak_meter_ballistics_top #(
    parameter int LEVEL_BITS = spmb_pkg::LEVEL_BITS_DEF,
    parameter int HOLD_BITS  = spmb_pkg::HOLD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_cfg_wr_en,
    input  wire logic [spmb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spmb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [spmb_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [spmb_pkg::VALUE_W-1:0]   i_left_value,
    input  wire logic [spmb_pkg::VALUE_W-1:0]   i_right_value,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [spmb_pkg::VALUE_W-1:0]        o_left_smooth_out,
    output logic [spmb_pkg::VALUE_W-1:0]        o_right_smooth_out,
    output logic [spmb_pkg::VALUE_W-1:0]        o_left_rms_out,
    output logic [spmb_pkg::VALUE_W-1:0]        o_right_rms_out,
    output logic [spmb_pkg::VALUE_W-1:0]        o_left_peak_out,
    output logic [spmb_pkg::VALUE_W-1:0]        o_right_peak_out,
    output logic                                o_left_clip_out,
    output logic                                o_right_clip_out
);
    import spmb_pkg::*;

    // signed product width for the smoothing step: level diff times 17-bit factor
    localparam int PRODW = LEVEL_BITS + 18;
    // width for the peak fall compare, covers level and step
    localparam int PW    = LEVEL_BITS + 16;
    localparam int CW    = LEVEL_BITS + 16;

    localparam logic [LEVEL_BITS-1:0] UNITY = LEVEL_BITS'(1) << (LEVEL_BITS - 2);
    localparam logic signed [PRODW-1:0] ROUND_HALF = PRODW'(32768);
    localparam logic [CW-1:0] K_LEVEL = CW'(DECAY_LEVEL_Q16);
    localparam logic [CW-1:0] K_RMS   = CW'(DECAY_RMS_Q16);

    // configuration registers
    logic [HOLD_CFG_W-1:0] r_hold_ticks;
    logic [STEP_W-1:0]     r_decay_step;
    logic [FACTOR_W-1:0]   r_smooth_f;

    // input register
    logic                  r_in_valid;
    t_req                  r_req;
    logic [VALUE_W-1:0]    r_val [2];

    // channel state, index 0 left, 1 right
    logic [LEVEL_BITS-1:0] r_lvl    [2];
    logic [LEVEL_BITS-1:0] r_smooth [2];
    logic [LEVEL_BITS-1:0] r_rms    [2];
    logic [LEVEL_BITS-1:0] r_peak   [2];
    logic [HOLD_BITS-1:0]  r_hold   [2];
    logic                  r_clip   [2];

    logic [LEVEL_BITS-1:0] n_lvl    [2];
    logic [LEVEL_BITS-1:0] n_smooth [2];
    logic [LEVEL_BITS-1:0] n_rms    [2];
    logic [LEVEL_BITS-1:0] n_peak   [2];
    logic [HOLD_BITS-1:0]  n_hold   [2];
    logic                  n_clip   [2];

    // result register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_smooth [2];
    logic [VALUE_W-1:0]    r_out_rms    [2];
    logic [VALUE_W-1:0]    r_out_peak   [2];
    logic                  r_out_clip   [2];

    // datapath intermediates
    logic [LEVEL_BITS-1:0]      set_val  [2];
    logic signed [LEVEL_BITS:0] diff     [2];
    logic signed [PRODW-1:0]    prod     [2];
    logic signed [PRODW-1:0]    adj      [2];
    logic signed [PRODW-1:0]    sm_sum   [2];
    logic [CW-1:0]              lvl_prod [2];
    logic [CW-1:0]              rms_prod [2];
    logic [PW-1:0]              peak_ext [2];
    logic [PW-1:0]              step_ext;
    logic signed [PRODW-1:0]    f_ext;

    logic out_free;
    logic do_step;

    // result slot is free when empty or being taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign do_step    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    assign step_ext = PW'(r_decay_step);
    assign f_ext    = $signed({{(PRODW-FACTOR_W){1'b0}}, r_smooth_f});

    // per-channel next state, channels are independent
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            set_val[c]  = LEVEL_BITS'(r_val[c]);
            // s + round((l - s) * f / 65536), stays between s and l
            diff[c]     = $signed({1'b0, r_lvl[c]}) - $signed({1'b0, r_smooth[c]});
            prod[c]     = PRODW'(diff[c]) * f_ext;
            adj[c]      = (prod[c] + ROUND_HALF) >>> 16;
            sm_sum[c]   = $signed({{(PRODW-LEVEL_BITS){1'b0}}, r_smooth[c]}) + adj[c];
            lvl_prod[c] = CW'(r_lvl[c]) * K_LEVEL;
            rms_prod[c] = CW'(r_rms[c]) * K_RMS;
            peak_ext[c] = PW'(r_peak[c]);

            n_lvl[c]    = r_lvl[c];
            n_smooth[c] = r_smooth[c];
            n_rms[c]    = r_rms[c];
            n_peak[c]   = r_peak[c];
            n_hold[c]   = r_hold[c];
            n_clip[c]   = r_clip[c];

            unique case (r_req)
                REQ_SET_LEVEL: begin
                    n_lvl[c] = set_val[c];
                    // exactly unity does not clip
                    if (set_val[c] > UNITY) begin
                        n_clip[c] = 1'b1;
                    end
                    if (set_val[c] > r_peak[c]) begin
                        n_peak[c] = set_val[c];
                        n_hold[c] = HOLD_BITS'(r_hold_ticks);
                    end
                end
                REQ_SET_RMS: begin
                    n_rms[c] = set_val[c];
                end
                REQ_TICK: begin
                    n_smooth[c] = sm_sum[c][LEVEL_BITS-1:0];
                    n_lvl[c]    = lvl_prod[c][CW-1:16];
                    n_rms[c]    = rms_prod[c][CW-1:16];
                    if (r_hold[c] != '0) begin
                        n_hold[c] = r_hold[c] - HOLD_BITS'(1);
                    end else if (peak_ext[c] > step_ext) begin
                        n_peak[c] = LEVEL_BITS'(peak_ext[c] - step_ext);
                    end else begin
                        n_peak[c] = '0;
                    end
                end
                REQ_CLR_CLIP: begin
                    n_clip[c] = 1'b0;
                end
                REQ_CLR_PEAK: begin
                    n_peak[c] = '0;
                    n_hold[c] = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RST;
            r_decay_step <= DECAY_STEP_RST;
            r_smooth_f   <= SMOOTH_F_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_lvl[c]    <= '0;
                r_smooth[c] <= '0;
                r_rms[c]    <= '0;
                r_peak[c]   <= '0;
                r_hold[c]   <= '0;
                r_clip[c]   <= 1'b0;
            end
        end else begin
            // config writes, unknown index ignored
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_HOLD_TICKS: r_hold_ticks <= HOLD_CFG_W'(i_cfg_wdata);
                    CFG_DECAY_STEP: r_decay_step <= STEP_W'(i_cfg_wdata);
                    CFG_SMOOTH_F:   r_smooth_f   <= FACTOR_W'(i_cfg_wdata);
                    default: begin
                    end
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end

            if (do_step) begin
                for (int c = 0; c < 2; c++) begin
                    r_lvl[c]    <= n_lvl[c];
                    r_smooth[c] <= n_smooth[c];
                    r_rms[c]    <= n_rms[c];
                    r_peak[c]   <= n_peak[c];
                    r_hold[c]   <= n_hold[c];
                    r_clip[c]   <= n_clip[c];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req    <= t_req'(i_req_type);
            r_val[0] <= i_left_value;
            r_val[1] <= i_right_value;
        end
        if (do_step) begin
            for (int c = 0; c < 2; c++) begin
                r_out_smooth[c] <= VALUE_W'(n_smooth[c]);
                r_out_rms[c]    <= VALUE_W'(n_rms[c]);
                r_out_peak[c]   <= VALUE_W'(n_peak[c]);
                r_out_clip[c]   <= n_clip[c];
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_left_smooth_out  = r_out_smooth[0];
    assign o_right_smooth_out = r_out_smooth[1];
    assign o_left_rms_out     = r_out_rms[0];
    assign o_right_rms_out    = r_out_rms[1];
    assign o_left_peak_out    = r_out_peak[0];
    assign o_right_peak_out   = r_out_peak[1];
    assign o_left_clip_out    = r_out_clip[0];
    assign o_right_clip_out   = r_out_clip[1];

`ifndef ASSERT_OFF
    // a running left hold always belongs to a captured, nonzero left peak
    a_hold_implies_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold[0] != '0) |-> (r_peak[0] != '0))
        else $error("left hold running with zero peak");

    // a stalled request stays in the input register
    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("stalled request dropped");

    // clear clip shows both latches low in its result
    a_clear_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && r_req == REQ_CLR_CLIP) |=> (!o_left_clip_out && !o_right_clip_out))
        else $error("clip latch not cleared");

    // clear peaks shows both peaks at zero in its result
    a_clear_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_step && r_req == REQ_CLR_PEAK) |=>
        (o_left_peak_out == '0 && o_right_peak_out == '0))
        else $error("peak not cleared");
`endif

endmodule

`default_nettype wire
